// ===== src/lse_pkg.sv =====
// Shared types and constants for the line splitter with line-ending detection.
// No dependencies.
`default_nettype none

package lse_pkg;

   localparam logic [7:0] CHAR_NUL = 8'd0;
   localparam logic [7:0] CHAR_LF  = 8'd10;
   localparam logic [7:0] CHAR_CR  = 8'd13;

   typedef enum logic [1:0] {
      OP_DATA = 2'd0,
      OP_EOB  = 2'd1,
      OP_FIN  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      BS_TEXT = 2'd0,
      BS_CR   = 2'd1,
      BS_LF   = 2'd2
   } break_type;

   typedef enum logic [1:0] {
      MODE_NONE = 2'd0,
      MODE_CR   = 2'd1,
      MODE_LF   = 2'd2,
      MODE_CRLF = 2'd3
   } mode_type;

   typedef struct packed {
      break_type break_state;
      mode_type  eol_mode;
      logic      line_has_text;
      logic      dropping_rest;
   } state_type;

   // Results of one input: an optional line end, then an optional text byte.
   typedef struct packed {
      logic       has_eol;
      logic       eol_empty;
      logic       has_text;
      logic [7:0] text_byte;
   } entry_type;

endpackage

`default_nettype wire

// ===== src/lse_step.sv =====
// Next-state and result decode for one input item of the line splitter.
// Depends on lse_pkg.
`default_nettype none

module lse_step (
   input  wire lse_pkg::state_type st_cur,
   input  wire logic [1:0]         op,
   input  wire logic [7:0]         byte_in,
   output lse_pkg::state_type      st_nxt,
   output lse_pkg::entry_type      res
);
   import lse_pkg::*;

   logic eol;
   logic text;

   always_comb begin
      st_nxt = st_cur;
      eol    = 1'b0;
      text   = 1'b0;

      case (op_type'(op))
         OP_DATA: begin
            if (!st_cur.dropping_rest) begin
               if (byte_in == CHAR_NUL) begin
                  st_nxt.dropping_rest = 1'b1;
               end else if (byte_in == CHAR_CR) begin
                  unique case (st_cur.eol_mode)
                     MODE_CR:   eol = 1'b1;
                     MODE_LF:   ;
                     MODE_CRLF: st_nxt.break_state = BS_CR;
                     default: begin
                        if (st_cur.break_state == BS_TEXT) begin
                           st_nxt.break_state = BS_CR;
                        end else if (st_cur.break_state == BS_CR) begin
                           st_nxt.eol_mode    = MODE_CR;
                           st_nxt.break_state = BS_TEXT;
                           eol                = 1'b1;
                        end else begin
                           // LF then CR: a line end, mode still open
                           st_nxt.break_state = BS_TEXT;
                           eol                = 1'b1;
                        end
                     end
                  endcase
               end else if (byte_in == CHAR_LF) begin
                  unique case (st_cur.eol_mode)
                     MODE_CR: ;
                     MODE_LF: eol = 1'b1;
                     MODE_CRLF: begin
                        if (st_cur.break_state == BS_CR) begin
                           st_nxt.break_state = BS_TEXT;
                           eol                = 1'b1;
                        end
                     end
                     default: begin
                        if (st_cur.break_state == BS_TEXT) begin
                           st_nxt.break_state = BS_LF;
                        end else if (st_cur.break_state == BS_CR) begin
                           st_nxt.eol_mode    = MODE_CRLF;
                           st_nxt.break_state = BS_TEXT;
                           eol                = 1'b1;
                        end else begin
                           st_nxt.eol_mode    = MODE_LF;
                           st_nxt.break_state = BS_TEXT;
                           eol                = 1'b1;
                        end
                     end
                  endcase
               end else begin
                  if (st_cur.break_state == BS_CR) begin
                     st_nxt.eol_mode    = MODE_CR;
                     st_nxt.break_state = BS_TEXT;
                     eol                = 1'b1;
                  end else if (st_cur.break_state == BS_LF) begin
                     st_nxt.eol_mode    = MODE_LF;
                     st_nxt.break_state = BS_TEXT;
                     eol                = 1'b1;
                  end
                  text = 1'b1;
               end
            end
         end
         OP_EOB: begin
            if (st_cur.dropping_rest) begin
               st_nxt.dropping_rest = 1'b0;
            end else if (st_cur.break_state == BS_CR || st_cur.break_state == BS_LF) begin
               st_nxt.break_state = BS_TEXT;
               eol                = 1'b1;
            end
         end
         OP_FIN: begin
            st_nxt.dropping_rest = 1'b0;
            if (st_cur.break_state == BS_TEXT) begin
               eol = 1'b1;
            end
         end
         default: ;
      endcase

      // line end clears the text flag, a following text byte sets it again
      if (eol) begin
         st_nxt.line_has_text = 1'b0;
      end
      if (text) begin
         st_nxt.line_has_text = 1'b1;
      end

      res.has_eol   = eol;
      res.eol_empty = ~st_cur.line_has_text;
      res.has_text  = text;
      res.text_byte = byte_in;
   end

endmodule

`default_nettype wire

// ===== src/line_splitter_autodetect_eol.sv =====
// Line splitter with CR / LF / CRLF detection: top level, state and result queue.
// Results are offered from a queue, no sooner than the cycle after input acceptance.
// One input beat per cycle while the queue has room or pops; an input giving a line
// end and a text byte is sent as a line-end result beat, then a text result beat.
// A two-entry result queue lets input continue while a result waits.
// Synchronous active-high reset clears the line state and empties the queue.
// Depends on lse_pkg and lse_step.
`default_nettype none

module line_splitter_autodetect_eol (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_op,
   input  wire logic [7:0] req_byte_in,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_kind,
   output logic [7:0]      rsp_byte_out,
   output logic            rsp_line_empty,
   output logic            rsp_last
);
   import lse_pkg::*;

   state_type state_ff, state_in, state_nxt;
   entry_type step_res;
   entry_type q_ff [2];
   entry_type head;
   logic      wr_ptr_ff, wr_ptr_in;
   logic      rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic      sub_ff, sub_in;
   logic      accept, push, pop, rsp_beat, eol_part;

   lse_step u_step (
      .st_cur  (state_ff),
      .op      (req_op),
      .byte_in (req_byte_in),
      .st_nxt  (state_nxt),
      .res     (step_res)
   );

   assign head     = q_ff[rd_ptr_ff];
   assign eol_part = head.has_eol & ~sub_ff;

   assign rsp_valid      = (count_ff != 2'd0);
   assign rsp_kind       = eol_part;
   assign rsp_byte_out   = eol_part ? 8'd0 : head.text_byte;
   assign rsp_line_empty = eol_part & head.eol_empty;
   assign rsp_last       = ~(eol_part & head.has_text);

   assign rsp_beat  = rsp_valid & rsp_ready;
   assign pop       = rsp_beat & rsp_last;
   assign req_ready = (count_ff != 2'd2) | pop;
   assign accept    = req_valid & req_ready;
   assign push      = accept & (step_res.has_eol | step_res.has_text);

   always_comb begin
      state_in  = accept ? state_nxt : state_ff;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
      sub_in    = sub_ff;
      if (rsp_beat) begin
         sub_in = ~rsp_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= '{break_state: BS_TEXT, eol_mode: MODE_NONE,
                        line_has_text: 1'b0, dropping_rest: 1'b0};
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
         sub_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         sub_ff    <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= step_res;
      end
   end

   // second half of a head entry only exists when it carries both parts
   a_sub_pair: assert property (@(posedge clock) disable iff (reset)
      sub_ff |-> (rsp_valid && head.has_eol && head.has_text))
      else $error("line end / text split on an entry without both parts");

   a_mode_sticky: assert property (@(posedge clock) disable iff (reset)
      (state_ff.eol_mode != MODE_NONE) |=> (state_ff.eol_mode != MODE_NONE))
      else $error("detected line-ending mode lost");

   a_single_mode_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff.eol_mode == MODE_CR || state_ff.eol_mode == MODE_LF)
         |-> (state_ff.break_state == BS_TEXT))
      else $error("break pending in a single-character mode");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue overfilled");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2 && !pop) |-> !accept)
      else $error("beat accepted into a full result queue");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for line_splitter_autodetect_eol: a directed table, then random
// lines and noise, checked beat by beat against a line-ending predictor.
// Depends on lse_pkg and the line_splitter_autodetect_eol RTL.

module testbench;

   import lse_pkg::*;

   localparam logic [1:0] OP_RSVD     = 2'd3;   // unused op, must be ignored
   localparam logic       KIND_TEXT   = 1'b0;
   localparam logic       KIND_EOL    = 1'b1;
   localparam int         N_DIRECTED  = 25;
   localparam int         ITEM_TARGET = 500;
   localparam int         SWITCH_AT   = 260;    // hand-over from CR LF to CR-only mode
   localparam int         IDLE_LIMIT  = 2000;
   localparam int         DRAIN_WAIT  = 16;

   typedef struct packed {
      logic       kind;
      logic [7:0] byte_out;
      logic       line_empty;
      logic       last;
   } rsp_beat_t;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] data;
      logic       typed;    // expectation written out in res
      logic       n_res;    // typed rows give at most one result
      rsp_beat_t  res;
   } stim_row_t;

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_MASK} rx_style_t;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_op;
   logic [7:0] req_byte_in;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_kind;
   logic [7:0] rsp_byte_out;
   logic       rsp_line_empty;
   logic       rsp_last;

   // predictor state
   break_type brk_q;
   mode_type  mode_q;
   logic      text_q;
   logic      drop_q;

   rsp_beat_t predicted[$];
   rsp_beat_t expected_lines[$];

   int        failures = 0;
   int        beats_sent = 0;
   int        results_seen = 0;
   int        line_ends_seen = 0;
   int        burst_left = 0;
   int        idle_cycles = 0;
   bit        keep_crlf = 1'b1;
   logic [3:0] modes_seen = '0;

   rx_style_t  rx_style = RX_OPEN;
   logic [7:0] rx_mask = 8'hFF;
   logic [6:0] rx_count = '0;

   stim_row_t directed_rows [N_DIRECTED] = '{
      '{OP_FIN,  8'h00,    1'b1, 1'b1, '{KIND_EOL,  8'h00, 1'b1, 1'b1}},
      '{OP_DATA, 8'h41,    1'b1, 1'b1, '{KIND_TEXT, 8'h41, 1'b0, 1'b1}},
      '{OP_DATA, 8'hFF,    1'b1, 1'b1, '{KIND_TEXT, 8'hFF, 1'b0, 1'b1}},
      '{OP_DATA, 8'h01,    1'b1, 1'b1, '{KIND_TEXT, 8'h01, 1'b0, 1'b1}},
      '{OP_DATA, CHAR_CR,  1'b1, 1'b0, '0},
      '{OP_EOB,  8'hA5,    1'b0, 1'b0, '0},   // flushes pending CR, mode still unknown
      '{OP_DATA, CHAR_LF,  1'b0, 1'b0, '0},
      '{OP_FIN,  8'hFF,    1'b0, 1'b0, '0},   // break pending: no line end
      '{OP_EOB,  8'h00,    1'b0, 1'b0, '0},
      '{OP_RSVD, 8'h5A,    1'b1, 1'b0, '0},
      '{OP_DATA, CHAR_NUL, 1'b1, 1'b0, '0},
      '{OP_DATA, 8'h80,    1'b0, 1'b0, '0},
      '{OP_DATA, CHAR_CR,  1'b0, 1'b0, '0},
      '{OP_EOB,  8'h00,    1'b1, 1'b0, '0},   // end of a dropped buffer: no flush
      '{OP_DATA, 8'h7F,    1'b0, 1'b0, '0},
      '{OP_DATA, CHAR_LF,  1'b0, 1'b0, '0},
      '{OP_DATA, CHAR_CR,  1'b0, 1'b0, '0},   // LF then CR: line end, nothing learnt
      '{OP_DATA, CHAR_NUL, 1'b0, 1'b0, '0},
      '{OP_FIN,  8'h00,    1'b0, 1'b0, '0},   // clears the drop as well
      '{OP_DATA, CHAR_CR,  1'b0, 1'b0, '0},
      '{OP_DATA, CHAR_LF,  1'b0, 1'b0, '0},   // CR LF learnt here
      '{OP_DATA, 8'h55,    1'b0, 1'b0, '0},
      '{OP_DATA, CHAR_LF,  1'b0, 1'b0, '0},   // lone LF ignored in CR LF mode
      '{OP_DATA, CHAR_CR,  1'b0, 1'b0, '0},
      '{OP_DATA, CHAR_LF,  1'b0, 1'b0, '0}
   };

   line_splitter_autodetect_eol dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_byte_in    (req_byte_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_byte_out   (rsp_byte_out),
      .rsp_line_empty (rsp_line_empty),
      .rsp_last       (rsp_last)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic void add_eol();
      rsp_beat_t r;
      r = '{kind: KIND_EOL, byte_out: 8'h00, line_empty: !text_q, last: 1'b0};
      predicted.push_back(r);
      text_q = 1'b0;
   endfunction

   function automatic void add_text(input logic [7:0] b);
      rsp_beat_t r;
      r = '{kind: KIND_TEXT, byte_out: b, line_empty: 1'b0, last: 1'b0};
      predicted.push_back(r);
      text_q = 1'b1;
   endfunction

   function automatic void split_byte(input logic [7:0] b);
      if (b == CHAR_NUL) begin
         drop_q = 1'b1;
      end else if (b == CHAR_CR) begin
         case (mode_q)
            MODE_CR: add_eol();
            MODE_LF: ;                          // wrong break, ignored
            MODE_CRLF: brk_q = BS_CR;
            default: begin
               if (brk_q == BS_TEXT) begin
                  brk_q = BS_CR;
               end else begin
                  if (brk_q == BS_CR) mode_q = MODE_CR;
                  brk_q = BS_TEXT;
                  add_eol();
               end
            end
         endcase
      end else if (b == CHAR_LF) begin
         case (mode_q)
            MODE_CR: ;
            MODE_LF: add_eol();
            MODE_CRLF: begin
               if (brk_q == BS_CR) begin
                  brk_q = BS_TEXT;
                  add_eol();
               end
            end
            default: begin
               if (brk_q == BS_TEXT) begin
                  brk_q = BS_LF;
               end else begin
                  if (brk_q == BS_CR) mode_q = MODE_CRLF;
                  else mode_q = MODE_LF;
                  brk_q = BS_TEXT;
                  add_eol();
               end
            end
         endcase
      end else begin
         // text after a pending break settles the mode on that break alone
         if (brk_q != BS_TEXT) begin
            if (brk_q == BS_CR) mode_q = MODE_CR;
            else mode_q = MODE_LF;
            brk_q = BS_TEXT;
            add_eol();
         end
         add_text(b);
      end
   endfunction

   function automatic void predict_split(input logic [1:0] op, input logic [7:0] b);
      predicted.delete();
      case (op)
         OP_DATA: if (!drop_q) split_byte(b);
         OP_EOB: begin
            if (drop_q) begin
               drop_q = 1'b0;
            end else if (brk_q != BS_TEXT) begin
               brk_q = BS_TEXT;
               add_eol();
            end
         end
         OP_FIN: begin
            drop_q = 1'b0;
            if (brk_q == BS_TEXT) add_eol();
         end
         default: ;
      endcase
      if (predicted.size() != 0) predicted[predicted.size() - 1].last = 1'b1;
      modes_seen[mode_q] = 1'b1;
   endfunction

   function automatic logic [7:0] pick_text();
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255));
      while (b == CHAR_CR || b == CHAR_LF);
      return b;
   endfunction

   function automatic void check_field(input string field, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         failures++;
      end
   endfunction

   task automatic drive_beat(input logic [1:0] op, input logic [7:0] data,
                             input logic typed, input logic n_res, input rsp_beat_t res);
      int gap;
      req_valid   <= 1'b1;
      req_op      <= op;
      req_byte_in <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_split(op, data);
      if (typed) begin
         if (n_res) expected_lines.push_back(res);
      end else begin
         foreach (predicted[i]) expected_lines.push_back(predicted[i]);
      end
      beats_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         if ($urandom_range(0, 2) == 0) gap = 0;
         else if ($urandom_range(0, 7) == 0) gap = $urandom_range(10, 30);
         else gap = $urandom_range(1, 4);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_item(input logic [1:0] op, input logic [7:0] data);
      logic [7:0] b;
      b = data;
      // until the planned hand-over, never let text follow a pending CR in CR LF mode
      if (keep_crlf && op == OP_DATA && !drop_q && mode_q == MODE_CRLF && brk_q == BS_CR
          && b != CHAR_NUL && b != CHAR_CR && b != CHAR_LF)
         b = CHAR_LF;
      drive_beat(op, b, 1'b0, 1'b0, '0);
   endtask

   task automatic drain_pause();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_lines.size() != 0) @(posedge clock);
   endtask

   task automatic send_line();
      int n_text;
      int cut;
      n_text = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 10);
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n_text) : -1;
      for (int i = 0; i < n_text; i++)
         send_item(OP_DATA, (i == cut) ? CHAR_NUL : pick_text());
      case (mode_q)
         MODE_CR: send_item(OP_DATA, CHAR_CR);
         MODE_LF: send_item(OP_DATA, CHAR_LF);
         default: begin
            send_item(OP_DATA, CHAR_CR);
            if ($urandom_range(0, 7) == 0) send_item(OP_EOB, 8'($urandom));
            send_item(OP_DATA, CHAR_LF);
         end
      endcase
      if (cut >= 0 || $urandom_range(0, 3) == 0) send_item(OP_EOB, 8'($urandom));
   endtask

   task automatic send_noise();
      logic [7:0] b;
      case ($urandom_range(0, 5))
         0: b = CHAR_NUL;
         1: b = CHAR_CR;
         2: b = CHAR_LF;
         default: b = 8'($urandom);
      endcase
      case ($urandom_range(0, 9))
         6, 7: send_item(OP_EOB, b);
         8: send_item(OP_FIN, b);
         9: send_item(OP_RSVD, b);
         default: send_item(OP_DATA, b);
      endcase
   endtask

   // receiver stalls: a new style each time rx_count wraps to zero
   always @(posedge clock) begin
      rx_count <= rx_count + 7'd1;
      if (rx_count == 7'd0) begin
         rx_style <= rx_style_t'($urandom_range(0, 3));
         rx_mask  <= 8'($urandom) | 8'h01;
      end
      case (rx_style)
         RX_OPEN:   rsp_ready <= 1'b1;
         RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
         RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:   rsp_ready <= rx_mask[rx_count[2:0]];
      endcase
   end

   always @(posedge clock) begin
      rsp_beat_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_lines.size() == 0) begin
            $error("result beat with none expected: kind %0d byte %0d", rsp_kind, rsp_byte_out);
            failures++;
         end else begin
            want = expected_lines.pop_front();
            check_field("kind", 8'(want.kind), 8'(rsp_kind));
            check_field("byte_out", want.byte_out, rsp_byte_out);
            check_field("line_empty", 8'(want.line_empty), 8'(rsp_line_empty));
            check_field("last", 8'(want.last), 8'(rsp_last));
         end
         results_seen++;
         if (rsp_kind == KIND_EOL) line_ends_seen++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      brk_q  = BS_TEXT;
      mode_q = MODE_NONE;
      text_q = 1'b0;
      drop_q = 1'b0;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_op      <= OP_DATA;
      req_byte_in <= 8'h00;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         drive_beat(directed_rows[i].op, directed_rows[i].data, directed_rows[i].typed,
                    directed_rows[i].n_res, directed_rows[i].res);

      while (beats_sent < ITEM_TARGET) begin
         if (keep_crlf && beats_sent >= SWITCH_AT) begin
            drain_pause();
            // two buffer ends clear any drop and flush any pending CR
            send_item(OP_EOB, 8'h00);
            send_item(OP_EOB, 8'h00);
            keep_crlf = 1'b0;
            send_item(OP_DATA, CHAR_CR);
            send_item(OP_DATA, pick_text());
         end else if ($urandom_range(0, 4) == 0) begin
            send_noise();
         end else begin
            send_line();
         end
      end
      req_valid <= 1'b0;

      while (expected_lines.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Sent %0d input beats (%0d from the table); checked %0d result beats, %0d line ends",
               beats_sent, N_DIRECTED, results_seen, line_ends_seen);
      $display("Line-ending modes visited (bit per mode): %b, finishing in %s",
               modes_seen, mode_q.name());
      if (failures == 0 && expected_lines.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/lse_pkg.sv
src/lse_step.sv
src/line_splitter_autodetect_eol.sv
test/testbench.sv
